// ===== hdl/ulid_pkg.sv =====
// Shared types, constants and the Crockford base32 alphabet for the ULID generator.
`timescale 1ns / 1ps

package ulid_pkg;

    localparam int TS_W      = 48;
    localparam int RAND_HI_W = 16;
    localparam int RAND_LO_W = 64;
    localparam int RAND_W    = RAND_HI_W + RAND_LO_W;
    localparam int SYM_W     = 5;
    localparam int ID_CHARS  = 26;
    localparam int SHIFT_W   = ID_CHARS * SYM_W;
    localparam int POS_W     = 5;
    localparam int CODE_W    = 7;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(ID_CHARS - 1);

    localparam logic [CODE_W-1:0] ALPHABET [0:31] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
        7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
        7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
    };

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ulid_state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } ulid_cmd_t;

    typedef struct packed {
        logic last;
    } ulid_sts_t;

endpackage

// ===== hdl/ulid_ctrl.sv =====
// Controller: accepts requests and paces the 26 character words out.
`timescale 1ns / 1ps

module ulid_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ulid_pkg::ulid_sts_t sts,
    output ulid_pkg::ulid_cmd_t cmd
);

    ulid_pkg::ulid_state_t state_reg;
    ulid_pkg::ulid_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ulid_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            ulid_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ulid_pkg::ST_EMIT;
                end
            end
            ulid_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                // take the next request as the last word leaves
                s_ready = sts.last && m_ready;
                if (m_ready) begin
                    cmd.advance = 1'b1;
                    if (sts.last) begin
                        if (s_valid) begin
                            cmd.load = 1'b1;
                        end else begin
                            state_next = ulid_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ulid_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ulid_dp.sv =====
// Datapath: timestamp and random state, monotonic increment, character shifter.
`timescale 1ns / 1ps

module ulid_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [ulid_pkg::TS_W-1:0]            s_timestamp_ms,
    input  logic [ulid_pkg::RAND_HI_W-1:0]       s_fresh_random_high,
    input  logic [ulid_pkg::RAND_LO_W-1:0]       s_fresh_random_low,
    input  ulid_pkg::ulid_cmd_t                  cmd,
    output ulid_pkg::ulid_sts_t                  sts,
    output logic [ulid_pkg::CODE_W-1:0]          m_char_code,
    output logic [ulid_pkg::POS_W-1:0]           m_char_position,
    output logic                                 m_last_char
);

    logic [ulid_pkg::TS_W-1:0]    prev_time_reg;
    logic                         prev_valid_reg;
    logic [ulid_pkg::RAND_W-1:0]  rand_reg;
    logic [ulid_pkg::RAND_W-1:0]  rand_next;
    logic [ulid_pkg::SHIFT_W-1:0] shift_reg;
    logic [ulid_pkg::POS_W-1:0]   pos_reg;
    logic                         same_ts;

    assign same_ts = prev_valid_reg && (s_timestamp_ms == prev_time_reg);

    // same millisecond: bump the random part, wrapping at all ones
    assign rand_next = same_ts ? (rand_reg + ulid_pkg::RAND_W'(1))
                               : {s_fresh_random_high, s_fresh_random_low};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
            pos_reg        <= '0;
        end else if (cmd.load) begin
            prev_valid_reg <= 1'b1;
            pos_reg        <= '0;
        end else if (cmd.advance) begin
            pos_reg        <= pos_reg + ulid_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            prev_time_reg <= s_timestamp_ms;
            rand_reg      <= rand_next;
            shift_reg     <= {2'b00, s_timestamp_ms, rand_next};
        end else if (cmd.advance) begin
            shift_reg     <= {shift_reg[ulid_pkg::SHIFT_W-ulid_pkg::SYM_W-1:0],
                              {ulid_pkg::SYM_W{1'b0}}};
        end
    end

    assign sts.last        = (pos_reg == ulid_pkg::LAST_POS);
    assign m_char_code     =
        ulid_pkg::ALPHABET[shift_reg[ulid_pkg::SHIFT_W-1 -: ulid_pkg::SYM_W]];
    assign m_char_position = pos_reg;
    assign m_last_char     = sts.last;

endmodule

// ===== hdl/monotonic_ulid_generator.sv =====
// Top level of the monotonic ULID generator: controller, datapath and checks.
`timescale 1ns / 1ps

// Each accepted request yields 26 Crockford base32 ASCII words, leftmost first:
// ten for the timestamp, then sixteen for the 80-bit random part, with
// m_last_char high on the final word. When the timestamp equals the previous
// one, the stored random part is incremented (wrapping to zero) instead of
// taking the fresh bits. While m_ready is high the output shifter moves one
// 5-bit symbol per cycle, and the next request is taken in the same cycle the
// last word of the current one is accepted.
module monotonic_ulid_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [47:0] s_timestamp_ms,
    input  logic [15:0] s_fresh_random_high,
    input  logic [63:0] s_fresh_random_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_char_code,
    output logic [4:0]  m_char_position,
    output logic        m_last_char
);

    ulid_pkg::ulid_cmd_t cmd;
    ulid_pkg::ulid_sts_t sts;

    ulid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ulid_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_timestamp_ms      (s_timestamp_ms),
        .s_fresh_random_high (s_fresh_random_high),
        .s_fresh_random_low  (s_fresh_random_low),
        .cmd                 (cmd),
        .sts                 (sts),
        .m_char_code         (m_char_code),
        .m_char_position     (m_char_position),
        .m_last_char         (m_last_char)
    );

    a_start_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid && (m_char_position == '0))
        else $error("new request did not start at position zero");

    a_position_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_char
        |=> m_valid && (m_char_position == 5'($past(m_char_position) + 5'd1)))
        else $error("character position did not advance by one");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("idle block not ready for a request");

    a_overlap_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_last_char && m_ready)
        else $error("request taken before the last word left");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the monotonic ULID generator.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_REQS = 340;
    localparam int STALL_LIMIT = 3000;
    localparam int PRESSURE_AT = ulid_pkg::ID_CHARS * 60;
    localparam int PRESSURE_CYCLES = 400;
    localparam int MAX_REPORTS = 30;

    typedef struct packed {
        logic [ulid_pkg::CODE_W-1:0] code;
        logic [ulid_pkg::POS_W-1:0]  pos;
        logic                        last;
    } ulid_char_t;

    logic                        aclk;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [ulid_pkg::TS_W-1:0]   s_timestamp_ms = '0;
    logic [15:0]                 s_fresh_random_high = '0;
    logic [63:0]                 s_fresh_random_low = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [ulid_pkg::CODE_W-1:0] m_char_code;
    logic [ulid_pkg::POS_W-1:0]  m_char_position;
    logic                        m_last_char;

    monotonic_ulid_generator uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_timestamp_ms      (s_timestamp_ms),
        .s_fresh_random_high (s_fresh_random_high),
        .s_fresh_random_low  (s_fresh_random_low),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_char_code         (m_char_code),
        .m_char_position     (m_char_position),
        .m_last_char         (m_last_char)
    );

    // Predictor state: last timestamp, whether one exists, 80-bit random part
    logic [ulid_pkg::TS_W-1:0]   last_ts = '0;
    logic                        have_ts = 1'b0;
    logic [ulid_pkg::RAND_W-1:0] rand_part = '0;

    string      crockford = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
    ulid_char_t pending_chars[$];
    string      typed_ids[$];

    int  err_count = 0;
    int  reqs_sent = 0;
    int  reqs_taken = 0;
    int  chars_checked = 0;
    int  ts_repeats = 0;
    int  rand_wraps = 0;
    int  stall_cycles = 0;
    bit  calm = 1'b0;
    bit  pressure_done = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Update the predictor with one request; return the 26 symbols, leftmost first
    task automatic compute_ulid(input logic [ulid_pkg::TS_W-1:0] ts, input logic [15:0] hi,
                                input logic [63:0] lo,
                                output logic [ulid_pkg::SHIFT_W-1:0] syms);
        if (have_ts && ts == last_ts) begin
            rand_part = rand_part + ulid_pkg::RAND_W'(1);
            ts_repeats++;
            if (rand_part == '0)
                rand_wraps++;
        end else begin
            rand_part = {hi, lo};
            last_ts = ts;
            have_ts = 1'b1;
        end
        syms = {2'b00, ts, rand_part};
    endtask

    // Queue the characters of one ULID; a typed id overrides the predicted codes
    task automatic queue_chars(input logic [ulid_pkg::SHIFT_W-1:0] syms, input string id);
        ulid_char_t                 c;
        logic [ulid_pkg::SYM_W-1:0] sym;
        byte                        ch;
        for (int i = 0; i < ulid_pkg::ID_CHARS; i++) begin
            sym = syms[ulid_pkg::SHIFT_W-1-ulid_pkg::SYM_W*i -: ulid_pkg::SYM_W];
            ch = (id.len() == ulid_pkg::ID_CHARS) ? id[i] : crockford[sym];
            c.code = ch[ulid_pkg::CODE_W-1:0];
            c.pos = ulid_pkg::POS_W'(i);
            c.last = (i == ulid_pkg::ID_CHARS - 1);
            pending_chars.insert(pending_chars.size(), c);
        end
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [ulid_pkg::TS_W-1:0] rand_ts();
        logic [63:0] v;
        v = rand64();
        case ($urandom_range(0, 3))
            0: return ulid_pkg::TS_W'($urandom_range(0, 31));
            1: return {ulid_pkg::TS_W{1'b1}} - ulid_pkg::TS_W'($urandom_range(0, 3));
            default: return v[ulid_pkg::TS_W-1:0];
        endcase
    endfunction

    // Offer one request and hold it until taken
    task automatic offer_request(input logic [ulid_pkg::TS_W-1:0] ts, input logic [15:0] hi,
                                 input logic [63:0] lo, input string id);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        typed_ids.insert(typed_ids.size(), id);
        s_valid <= 1'b1;
        s_timestamp_ms <= ts;
        s_fresh_random_high <= hi;
        s_fresh_random_low <= lo;
        do @(posedge aclk); while (!s_ready);
        reqs_sent++;
    endtask

    // Input side: predict each accepted request
    always @(posedge aclk) begin
        string                        id;
        logic [ulid_pkg::SHIFT_W-1:0] syms;
        if (aresetn && s_valid && s_ready) begin
            id = typed_ids.pop_front();
            compute_ulid(s_timestamp_ms, s_fresh_random_high, s_fresh_random_low, syms);
            queue_chars(syms, id);
            reqs_taken++;
        end
    end

    // Output side: compare each word with the oldest pending character
    always @(posedge aclk) begin
        ulid_char_t want;
        if (aresetn && m_valid && m_ready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, got code %0d pos %0d",
                             $time, m_char_code, m_char_position);
            end else begin
                want = pending_chars.pop_front();
                if (m_char_code !== want.code)
                    note_mismatch("char_code", int'(want.code), int'(m_char_code));
                if (m_char_position !== want.pos)
                    note_mismatch("char_position", int'(want.pos), int'(m_char_position));
                if (m_last_char !== want.last)
                    note_mismatch("last_char", int'(want.last), int'(m_last_char));
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("[monotonic_ulid_generator] ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!pressure_done && chars_checked >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                m_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge aclk);
            end else if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // Stimulus
    initial begin
        logic [ulid_pkg::TS_W-1:0] ts;
        logic [15:0]               hi;
        logic [63:0]               lo;
        int                        target;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first request with zero time, repeats, wraps, extremes
        offer_request(48'h0, 16'h0000, 64'h5,
                      {"0000000000", "0000000000000005"});
        offer_request(48'h0, 16'hFFFF, {64{1'b1}},
                      {"0000000000", "0000000000000006"});
        offer_request(48'h1, 16'hFFFF, {64{1'b1}},
                      {"0000000001", "ZZZZZZZZZZZZZZZZ"});
        offer_request(48'h1, 16'h1234, 64'h5678,
                      {"0000000001", "0000000000000000"});
        offer_request({ulid_pkg::TS_W{1'b1}}, 16'h0000, 64'h0,
                      {"7ZZZZZZZZZ", "0000000000000000"});
        offer_request({ulid_pkg::TS_W{1'b1}}, 16'hFFFF, {64{1'b1}},
                      {"7ZZZZZZZZZ", "0000000000000001"});
        offer_request(48'hAAAA_AAAA_AAAA, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, "");
        offer_request(48'h5555_5555_5555, 16'hAAAA, 64'h5555_5555_5555_5555, "");
        offer_request(48'h0123_4567_89AB, 16'h00FF, {64{1'b1}}, "");
        offer_request(48'h0123_4567_89AB, 16'h0000, 64'h0, "");
        offer_request(48'h0123_4567_89AB, 16'hFFFF, 64'h0, "");
        offer_request(48'h0123_4567_89AA, 16'h8000, 64'h0123_4567_89AB_CDEF, "");
        offer_request(48'h8000_0000_0000, 16'h0001, 64'hFEDC_BA98_7654_3210, "");
        offer_request(48'h0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFE, "");
        offer_request(48'h0, 16'h0000, 64'h0, "");
        offer_request(48'h0, 16'h0000, 64'h0, "");
        offer_request(48'h1F, 16'h1234, 64'h0, "");

        // Random: mostly bursts on one timestamp, some near wraps, some counting
        target = reqs_sent + RANDOM_REQS;
        while (reqs_sent < target) begin
            calm = (((target - reqs_sent) / 30) % 4 == 1);
            ts = rand_ts();
            case ($urandom_range(0, 99)) inside
                [0:49]: begin
                    offer_request(ts, 16'($urandom), rand64(), "");
                    repeat ($urandom_range(1, 6))
                        offer_request(ts, 16'($urandom), rand64(), "");
                end
                [50:64]: begin
                    hi = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
                    lo = ~64'($urandom_range(0, 3));
                    offer_request(ts, hi, lo, "");
                    repeat ($urandom_range(2, 6))
                        offer_request(ts, 16'($urandom), rand64(), "");
                end
                [65:79]: begin
                    repeat ($urandom_range(2, 5)) begin
                        offer_request(ts, 16'($urandom), rand64(), "");
                        ts = ts + ulid_pkg::TS_W'(1);
                    end
                end
                default: begin
                    offer_request(ts, 16'($urandom), rand64(), "");
                end
            endcase
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (pending_chars.size() != 0 || typed_ids.size() != 0) @(posedge aclk);
        repeat (2 * ulid_pkg::ID_CHARS) @(posedge aclk);

        $display("Ran %0d requests, %0d characters checked; %0d repeated timestamps",
                 reqs_taken, chars_checked, ts_repeats);
        $display("  with %0d random-part wraps and one long output hold-off", rand_wraps);
        if (err_count == 0) begin
            $display("[monotonic_ulid_generator] OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("[monotonic_ulid_generator] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ulid_pkg.sv
hdl/ulid_ctrl.sv
hdl/ulid_dp.sv
hdl/monotonic_ulid_generator.sv
test/tb_top.sv
